/* rtl/pip_pkg.sv */
// Shared types and constants for the point-in-polygon crossing test.
// Used by pip_front, pip_edge_mul, pip_accum and point_in_polygon_crossing.
package pip_pkg;

  // Result channel payload width: three flags padded to one byte
  localparam int OUT_DATA_W = 8;

  // Vertex counter codes (saturating two-bit count)
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_FULL = 2'd3;

  // Per-request control carried down the pipe
  typedef struct packed {
    logic first;   // request opens a polygon
    logic last;    // request closes a polygon, a result follows
    logic degen;   // fewer than three vertices seen so far
  } pip_ctrl_t;

  // Per-edge flags that need no product
  typedef struct packed {
    logic in_box;    // query inside the edge's closed bounding box
    logic straddle;  // edge crosses the query's horizontal line
    logic h_pos;     // edge height (by - ay) is positive
  } pip_eflag_t;

endpackage

/* rtl/point_in_polygon_crossing.sv */
// Point-in-polygon test, even-odd crossing rule, boundary counts as inside.
// Throughput: one vertex per cycle while no result waits at the output. The result
// for the last vertex passes through the operand, product and decision registers.
// The whole pipe holds while a result waits unaccepted in the output register.
// Reset (rst_n low, synchronous) clears valids, vertex count, parity and hit.
// Depends on pip_pkg, pip_front, pip_edge_mul, pip_accum.
module point_in_polygon_crossing #(
  parameter int COORD_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // query_x, query_y, vertex_x, vertex_y (lowest first), zero padded to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       in_tdata,
  // first_vertex
  input  logic                                    in_tuser,
  input  logic                                    in_tlast,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // inside_res, on_boundary, degenerate (lowest first), zero padded
  output logic [pip_pkg::OUT_DATA_W-1:0]          out_tdata
);
  import pip_pkg::*;

  logic en, accept;
  logic v1_r, v2_r;
  pip_ctrl_t ctrl1_r, ctrl2_r;
  logic signed [COORD_BITS:0] e1_dxa, e1_dyb, e1_dya, e1_dxb;
  logic signed [COORD_BITS:0] e2_dxa, e2_dyb, e2_dya, e2_dxb;
  pip_eflag_t e1_flag, e2_flag, e1_flag_m, e2_flag_m;
  logic signed [2*COORD_BITS+1:0] e1_lp, e1_rp, e2_lp, e2_rp;
  logic out_valid_r;

  // Global pipe enable: move unless a result is stuck at the output
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign out_tvalid = out_valid_r;

  pip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .accept       (accept),
    .query_x      (in_tdata[COORD_BITS-1:0]),
    .query_y      (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .vertex_x     (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .vertex_y     (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .first_vertex (in_tuser),
    .last_vertex  (in_tlast),
    .v1_r         (v1_r),
    .ctrl1_r      (ctrl1_r),
    .e1_dxa_r     (e1_dxa),
    .e1_dyb_r     (e1_dyb),
    .e1_dya_r     (e1_dya),
    .e1_dxb_r     (e1_dxb),
    .e1_flag_r    (e1_flag),
    .e2_dxa_r     (e2_dxa),
    .e2_dyb_r     (e2_dyb),
    .e2_dya_r     (e2_dya),
    .e2_dxb_r     (e2_dxb),
    .e2_flag_r    (e2_flag)
  );

  // Product stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl2_r <= ctrl1_r;
    end
  end

  pip_edge_mul #(.COORD_BITS(COORD_BITS)) u_mul_open (
    .clk    (clk),
    .en     (en),
    .dxa    (e1_dxa),
    .dyb    (e1_dyb),
    .dya    (e1_dya),
    .dxb    (e1_dxb),
    .flag   (e1_flag),
    .lp_r   (e1_lp),
    .rp_r   (e1_rp),
    .flag_r (e1_flag_m)
  );

  pip_edge_mul #(.COORD_BITS(COORD_BITS)) u_mul_close (
    .clk    (clk),
    .en     (en),
    .dxa    (e2_dxa),
    .dyb    (e2_dyb),
    .dya    (e2_dya),
    .dxb    (e2_dxb),
    .flag   (e2_flag),
    .lp_r   (e2_lp),
    .rp_r   (e2_rp),
    .flag_r (e2_flag_m)
  );

  pip_accum #(.COORD_BITS(COORD_BITS)) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .v2          (v2_r),
    .ctrl2       (ctrl2_r),
    .e1_lp       (e1_lp),
    .e1_rp       (e1_rp),
    .e1_flag     (e1_flag_m),
    .e2_lp       (e2_lp),
    .e2_rp       (e2_rp),
    .e2_flag     (e2_flag_m),
    .out_valid_r (out_valid_r),
    .out_data_r  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // A degenerate polygon never reports inside or boundary
  a_degen_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[0] && !out_tdata[1])
    else $error("degenerate result with inside or boundary set");

  // Boundary hit implies inside
  a_bnd_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("boundary result without inside");

  // A new result comes only from a closing request in the decision stage
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !ctrl2_r.last && en |=> !out_valid_r)
    else $error("result raised without a closing request");
`endif

endmodule

/* rtl/pip_front.sv */
// Front stage: polygon state (start, previous vertex, query, count) and
// edge operand capture for the open edge and the closing edge. Uses pip_pkg.
module pip_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          accept,
  input  logic signed [COORD_BITS-1:0]  query_x,
  input  logic signed [COORD_BITS-1:0]  query_y,
  input  logic signed [COORD_BITS-1:0]  vertex_x,
  input  logic signed [COORD_BITS-1:0]  vertex_y,
  input  logic                          first_vertex,
  input  logic                          last_vertex,
  output logic                          v1_r,
  output pip_pkg::pip_ctrl_t            ctrl1_r,
  output logic signed [COORD_BITS:0]    e1_dxa_r,
  output logic signed [COORD_BITS:0]    e1_dyb_r,
  output logic signed [COORD_BITS:0]    e1_dya_r,
  output logic signed [COORD_BITS:0]    e1_dxb_r,
  output pip_pkg::pip_eflag_t           e1_flag_r,
  output logic signed [COORD_BITS:0]    e2_dxa_r,
  output logic signed [COORD_BITS:0]    e2_dyb_r,
  output logic signed [COORD_BITS:0]    e2_dya_r,
  output logic signed [COORD_BITS:0]    e2_dxb_r,
  output pip_pkg::pip_eflag_t           e2_flag_r
);
  import pip_pkg::*;

  logic signed [COORD_BITS-1:0] start_x_r, start_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] held_qx_r, held_qy_r;
  logic [1:0]                   count_r;

  logic                         first_eff;
  logic [1:0]                   cnt_nxt;
  logic [1:0]                   count_nxt;
  pip_ctrl_t                    ctrl_nxt;

  // Vertex count and effective first mark
  always_comb begin
    first_eff = first_vertex || (count_r == CNT_NONE);
    if (first_eff) begin
      cnt_nxt = CNT_ONE;
    end else if (count_r == CNT_FULL) begin
      cnt_nxt = CNT_FULL;
    end else begin
      cnt_nxt = count_r + 2'd1;
    end
    count_nxt      = last_vertex ? CNT_NONE : cnt_nxt;
    ctrl_nxt.first = first_eff;
    ctrl_nxt.last  = last_vertex;
    ctrl_nxt.degen = (cnt_nxt != CNT_FULL);
  end

  // Edge tests share the held query: edges exist only after a first vertex
  function automatic logic signed [COORD_BITS:0] sdiff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] ax;
    logic signed [COORD_BITS:0] bx;
    ax = {a[COORD_BITS-1], a};
    bx = {b[COORD_BITS-1], b};
    return ax - bx;
  endfunction

  function automatic pip_eflag_t eflags(
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic signed [COORD_BITS-1:0] ax,
    input logic signed [COORD_BITS-1:0] ay,
    input logic signed [COORD_BITS-1:0] bx,
    input logic signed [COORD_BITS-1:0] by
  );
    pip_eflag_t f;
    logic       in_x;
    logic       in_y;
    in_x       = ((px >= ax) && (px <= bx)) || ((px >= bx) && (px <= ax));
    in_y       = ((py >= ay) && (py <= by)) || ((py >= by) && (py <= ay));
    f.in_box   = in_x && in_y;
    f.straddle = (ay > py) != (by > py);
    f.h_pos    = by > ay;
    return f;
  endfunction

  // Control registers of the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      count_r <= CNT_NONE;
    end else begin
      if (en) begin
        v1_r <= accept;
      end
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Polygon state and edge operands
  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl1_r   <= ctrl_nxt;
      // open edge: previous vertex to this vertex
      e1_dxa_r  <= sdiff(held_qx_r, prev_x_r);
      e1_dyb_r  <= sdiff(vertex_y, prev_y_r);
      e1_dya_r  <= sdiff(held_qy_r, prev_y_r);
      e1_dxb_r  <= sdiff(vertex_x, prev_x_r);
      e1_flag_r <= eflags(held_qx_r, held_qy_r, prev_x_r, prev_y_r, vertex_x, vertex_y);
      // closing edge: this vertex back to the start vertex
      e2_dxa_r  <= sdiff(held_qx_r, vertex_x);
      e2_dyb_r  <= sdiff(start_y_r, vertex_y);
      e2_dya_r  <= sdiff(held_qy_r, vertex_y);
      e2_dxb_r  <= sdiff(start_x_r, vertex_x);
      e2_flag_r <= eflags(held_qx_r, held_qy_r, vertex_x, vertex_y, start_x_r, start_y_r);
      prev_x_r  <= vertex_x;
      prev_y_r  <= vertex_y;
      if (first_eff) begin
        start_x_r <= vertex_x;
        start_y_r <= vertex_y;
        held_qx_r <= query_x;
        held_qy_r <= query_y;
      end
    end
  end

endmodule

/* rtl/pip_edge_mul.sv */
// Product stage for one edge: the two cross products of the edge test.
// Uses pip_pkg for the edge flag type.
module pip_edge_mul #(
  parameter int COORD_BITS = 24
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [COORD_BITS:0]      dxa,
  input  logic signed [COORD_BITS:0]      dyb,
  input  logic signed [COORD_BITS:0]      dya,
  input  logic signed [COORD_BITS:0]      dxb,
  input  pip_pkg::pip_eflag_t             flag,
  output logic signed [2*COORD_BITS+1:0]  lp_r,
  output logic signed [2*COORD_BITS+1:0]  rp_r,
  output pip_pkg::pip_eflag_t             flag_r
);
  import pip_pkg::*;

  logic signed [2*COORD_BITS+1:0] lp_nxt;
  logic signed [2*COORD_BITS+1:0] rp_nxt;

  // (px-ax)*(by-ay) and (py-ay)*(bx-ax)
  assign lp_nxt = dxa * dyb;
  assign rp_nxt = dya * dxb;

  always_ff @(posedge clk) begin
    if (en) begin
      lp_r   <= lp_nxt;
      rp_r   <= rp_nxt;
      flag_r <= flag;
    end
  end

endmodule

/* rtl/pip_accum.sv */
// Decision stage: boundary and crossing decisions for both edges, even-odd
// parity and boundary hit accumulation, and the result register. Uses pip_pkg.
module pip_accum #(
  parameter int COORD_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            v2,
  input  pip_pkg::pip_ctrl_t              ctrl2,
  input  logic signed [2*COORD_BITS+1:0]  e1_lp,
  input  logic signed [2*COORD_BITS+1:0]  e1_rp,
  input  pip_pkg::pip_eflag_t             e1_flag,
  input  logic signed [2*COORD_BITS+1:0]  e2_lp,
  input  logic signed [2*COORD_BITS+1:0]  e2_rp,
  input  pip_pkg::pip_eflag_t             e2_flag,
  output logic                            out_valid_r,
  output logic [pip_pkg::OUT_DATA_W-1:0]  out_data_r
);
  import pip_pkg::*;

  logic parity_r, hit_r;
  logic bnd1, crs1, bnd2, crs2;
  logic use1, use2;
  logic par_nxt, hit_nxt;
  logic [OUT_DATA_W-1:0] data_nxt;

  // Per-edge decisions: on boundary wins over a crossing
  always_comb begin
    bnd1 = e1_flag.in_box && (e1_lp == e1_rp);
    crs1 = !bnd1 && e1_flag.straddle &&
           (e1_flag.h_pos ? (e1_rp >= e1_lp) : (e1_rp <= e1_lp));
    bnd2 = e2_flag.in_box && (e2_lp == e2_rp);
    crs2 = !bnd2 && e2_flag.straddle &&
           (e2_flag.h_pos ? (e2_rp >= e2_lp) : (e2_rp <= e2_lp));
    use1 = !ctrl2.first;
    use2 = ctrl2.last && !ctrl2.degen;
  end

  // Accumulate and form the result
  always_comb begin
    par_nxt = (ctrl2.first ? 1'b0 : parity_r) ^ (use1 && crs1) ^ (use2 && crs2);
    hit_nxt = (ctrl2.first ? 1'b0 : hit_r) | (use1 && bnd1) | (use2 && bnd2);
    data_nxt = '0;
    if (ctrl2.degen) begin
      data_nxt[2] = 1'b1;
    end else begin
      data_nxt[0] = hit_nxt || par_nxt;
      data_nxt[1] = hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      parity_r    <= 1'b0;
      hit_r       <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2 && ctrl2.last;
      if (v2) begin
        parity_r <= par_nxt;
        hit_r    <= hit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2 && ctrl2.last) begin
      out_data_r <= data_nxt;
    end
  end

endmodule

/* test/point_in_polygon_crossing_test.sv */
// Self-checking bench for point_in_polygon_crossing: streams polygon vertices, predicts
// each inside/boundary/degenerate result in-bench and checks every accepted result.
// Depends on pip_pkg and the point_in_polygon_crossing RTL.
module point_in_polygon_crossing_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W  = 24;
  localparam int IN_W     = ((4*COORD_W+7)/8)*8;
  localparam int LIMIT    = 500000;
  localparam int DRAIN    = 16;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7fffff;
  localparam logic [7:0] RES_DEGEN = 8'b0000_0100;

  // One vertex request
  typedef struct packed {
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic                      first;
    logic                      last;
  } vert_req_t;

  // Result byte as it sits in out_tdata, lowest bit last
  typedef struct packed {
    logic [4:0] pad;
    logic       degen;
    logic       boundary;
    logic       in_poly;
  } poly_flags_t;

  // Directed stimulus row
  typedef struct {
    vert_req_t  req;
    bit         has_exp;
    logic [7:0] exp_data;
  } vert_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [IN_W-1:0]                 in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pip_pkg::OUT_DATA_W-1:0]  out_tdata;

  point_in_polygon_crossing #(.COORD_BITS(COORD_W)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  longint      start_x, start_y, prev_x, prev_y, held_qx, held_qy;
  bit          odd_crossings, boundary_hit;
  int          seen_count;

  poly_flags_t pending_flags[$];
  vert_row_t   directed_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int cycle_count = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_inside = 0;
  int n_bound = 0;
  int n_degen = 0;
  poly_flags_t want, got;

  // One edge against the held query point: boundary first, then crossing
  function automatic void edge_test(longint ax, longint ay, longint bx, longint by);
    longint px, py, cross_l, cross_r, h;
    bit     in_box, hit;
    px = held_qx;
    py = held_qy;
    cross_l = (px - ax) * (by - ay);
    cross_r = (py - ay) * (bx - ax);
    in_box = (px >= (ax < bx ? ax : bx)) && (px <= (ax < bx ? bx : ax)) &&
             (py >= (ay < by ? ay : by)) && (py <= (ay < by ? by : ay));
    if (cross_l == cross_r && in_box) begin
      boundary_hit = 1'b1;
      return;
    end
    // straddle: one end strictly above the query line
    if ((ay > py) != (by > py)) begin
      h = by - ay;
      hit = (h > 0) ? (cross_r >= cross_l) : (cross_r <= cross_l);
      if (hit) odd_crossings = ~odd_crossings;
    end
  endfunction

  // Advance the polygon state by one vertex; returns 1 when a result is due
  function automatic bit crossing_step(input vert_req_t r, output poly_flags_t res);
    longint vx, vy;
    vx = r.vx;
    vy = r.vy;
    res = '0;
    if (r.first || seen_count == 0) begin
      held_qx = r.qx;
      held_qy = r.qy;
      start_x = vx;
      start_y = vy;
      prev_x = vx;
      prev_y = vy;
      odd_crossings = 1'b0;
      boundary_hit = 1'b0;
      seen_count = 1;
    end else begin
      edge_test(prev_x, prev_y, vx, vy);
      prev_x = vx;
      prev_y = vy;
      if (seen_count < 3) seen_count++;
    end
    if (!r.last) return 1'b0;
    if (seen_count < 3) begin
      res.degen = 1'b1;
    end else begin
      // closing edge back to the start vertex
      edge_test(vx, vy, start_x, start_y);
      res.in_poly = boundary_hit | odd_crossings;
      res.boundary = boundary_hit;
    end
    seen_count = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("tb: mismatch on %s: got %0d want %0d (result %0d, cycle %0d)",
             what, got_v, want_v, n_results, cycle_count);
    err_count++;
  endtask

  // Drive one request, hold until taken, then record its expected result
  task automatic send_req(input vert_req_t r, input bit has_exp, input logic [7:0] exp_data);
    poly_flags_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r.vy, r.vx, r.qy, r.qx};
    in_tuser <= r.first;
    in_tlast <= r.last;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    if (crossing_step(r, res)) begin
      if (has_exp) res = poly_flags_t'(exp_data);
      pending_flags = {pending_flags, res};
    end
  endtask

  // Hold the input side until every pending result has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_flags.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input int qx, input int qy, input int vx, input int vy,
                         input bit first, input bit last, input bit has_exp,
                         input logic [7:0] exp_data);
    vert_row_t row;
    row.req.qx = COORD_W'(qx);
    row.req.qy = COORD_W'(qy);
    row.req.vx = COORD_W'(vx);
    row.req.vy = COORD_W'(vy);
    row.req.first = first;
    row.req.last = last;
    row.has_exp = has_exp;
    row.exp_data = exp_data;
    directed_rows = {directed_rows, row};
  endtask

  // Coordinate in one of several styles: full range, tiny grid, clustered, extremes
  function automatic logic signed [COORD_W-1:0] rand_coord(int style, longint base);
    longint span;
    case (style)
      0: return COORD_W'($urandom());
      1: return COORD_W'(($urandom_range(16) - 8) * 256);
      2: begin
        span = longint'(1) << $urandom_range(2, 16);
        return COORD_W'(base + $urandom_range(2 * span) - span);
      end
      default: begin
        case ($urandom_range(3))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Random polygons, mostly well formed, until the request count reaches target
  task automatic random_polygons(input int target);
    int        nv, style, noise, qsel, j;
    bit        junk_query;
    longint    base_x, base_y;
    logic signed [COORD_W-1:0] xs[12], ys[12];
    logic signed [COORD_W-1:0] qx, qy;
    vert_req_t r;
    while (n_sent < target) begin
      case ($urandom_range(99)) inside
        [0:7]:   nv = $urandom_range(1, 2);
        [8:92]:  nv = $urandom_range(3, 6);
        default: nv = $urandom_range(7, 12);
      endcase
      style = $urandom_range(3);
      base_x = $signed($urandom_range(32'h00ffffff) - 32'sh00800000);
      base_y = $signed($urandom_range(32'h00ffffff) - 32'sh00800000);
      for (int i = 0; i < nv; i++) begin
        xs[i] = rand_coord(style, base_x);
        ys[i] = rand_coord(style, base_y);
      end
      // query: on a vertex, halfway along an edge, or free
      qsel = $urandom_range(99);
      j = $urandom_range(nv - 1);
      if (qsel < 20) begin
        qx = xs[j];
        qy = ys[j];
      end else if (qsel < 35) begin
        qx = COORD_W'((longint'(xs[j]) + longint'(xs[(j + 1) % nv])) >>> 1);
        qy = COORD_W'((longint'(ys[j]) + longint'(ys[(j + 1) % nv])) >>> 1);
      end else begin
        qx = rand_coord(style, base_x);
        qy = rand_coord(style, base_y);
      end
      noise = $urandom_range(99);
      junk_query = ($urandom_range(1) != 0);
      for (int i = 0; i < nv; i++) begin
        r.vx = xs[i];
        r.vy = ys[i];
        r.qx = (i != 0 && junk_query) ? rand_coord(0, 0) : qx;
        r.qy = (i != 0 && junk_query) ? rand_coord(0, 0) : qy;
        r.first = (i == 0);
        r.last = (i == nv - 1);
        if (noise < 5 && i == 0) r.first = 1'b0;
        else if (noise < 8 && i == nv - 1) r.last = 1'b0;
        else if (noise >= 8 && noise < 12) begin
          r.first = $urandom_range(3) == 0;
          r.last = $urandom_range(3) == 0;
        end
        send_req(r, 1'b0, '0);
      end
    end
  endtask

  // Result monitor, receiver stalls and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      if (rst_n && out_tvalid && out_tready) begin
        got = poly_flags_t'(out_tdata);
        n_results++;
        if (pending_flags.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = pending_flags.pop_front();
          if (got.in_poly !== want.in_poly)
            report_mismatch("inside_res", got.in_poly, want.in_poly);
          if (got.boundary !== want.boundary)
            report_mismatch("on_boundary", got.boundary, want.boundary);
          if (got.degen !== want.degen) report_mismatch("degenerate", got.degen, want.degen);
          if (got.pad !== want.pad) report_mismatch("padding", got.pad, want.pad);
          n_inside += want.in_poly;
          n_bound += want.boundary;
          n_degen += want.degen;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    // Directed rows: degenerate shapes, extremes, boundary, missing first mark, restarts
    add_row(100, -100, 5, 5, 1'b0, 1'b1, 1'b1, RES_DEGEN);
    add_row(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 1'b1, 1'b1, RES_DEGEN);
    add_row(0, 0, C_MIN, C_MIN, 1'b1, 1'b0, 1'b0, '0);
    add_row(0, 0, C_MAX, C_MAX, 1'b0, 1'b1, 1'b1, RES_DEGEN);
    // square, point in the middle
    add_row(2048, 2048, 0, 0, 1'b1, 1'b0, 1'b0, '0);
    add_row(2048, 2048, 4096, 0, 1'b0, 1'b0, 1'b0, '0);
    add_row(2048, 2048, 4096, 4096, 1'b0, 1'b0, 1'b0, '0);
    add_row(2048, 2048, 0, 4096, 1'b0, 1'b1, 1'b0, '0);
    // square, point on the bottom edge
    add_row(2048, 0, 0, 0, 1'b1, 1'b0, 1'b0, '0);
    add_row(2048, 0, 4096, 0, 1'b0, 1'b0, 1'b0, '0);
    add_row(2048, 0, 4096, 4096, 1'b0, 1'b0, 1'b0, '0);
    add_row(2048, 0, 0, 4096, 1'b0, 1'b1, 1'b0, '0);
    // full-range triangle, point at origin
    add_row(0, 0, C_MIN, C_MIN, 1'b1, 1'b0, 1'b0, '0);
    add_row(0, 0, C_MAX, C_MIN, 1'b0, 1'b0, 1'b0, '0);
    add_row(0, 0, 0, C_MAX, 1'b0, 1'b1, 1'b0, '0);
    // same triangle without a first mark, point in the far corner
    add_row(C_MAX, C_MAX, C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, '0);
    add_row(C_MAX, C_MAX, C_MAX, C_MIN, 1'b0, 1'b0, 1'b0, '0);
    add_row(C_MAX, C_MAX, 0, C_MAX, 1'b0, 1'b1, 1'b0, '0);
    // polygon abandoned by a new first mark
    add_row(1, 1, 7, 7, 1'b1, 1'b0, 1'b0, '0);
    // repeated vertex equal to the point; stray query fields later on
    add_row(-256, 512, -256, 512, 1'b1, 1'b0, 1'b0, '0);
    add_row(C_MAX, C_MIN, -256, 512, 1'b0, 1'b0, 1'b0, '0);
    add_row(C_MIN, C_MAX, 1024, -1024, 1'b0, 1'b0, 1'b0, '0);
    add_row(-1, 0, -2048, -1024, 1'b0, 1'b1, 1'b0, '0);

    seen_count = 0;
    odd_crossings = 1'b0;
    boundary_hit = 1'b0;
    start_x = 0; start_y = 0; prev_x = 0; prev_y = 0; held_qx = 0; held_qy = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 81;
    foreach (directed_rows[k]) send_req(directed_rows[k].req, directed_rows[k].has_exp,
                                        directed_rows[k].exp_data);
    wait_results_drained();

    // Random phases: slow receiver, then slow sender, then full rate
    random_polygons(n_sent + 640);
    wait_results_drained();
    send_idle_pct = 81;
    recv_idle_pct = 21;
    random_polygons(n_sent + 640);
    wait_results_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_polygons(n_sent + 620);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("tb: %0d vertices sent, %0d results checked", n_sent, n_results);
    $display("tb: %0d inside, %0d on an edge, %0d degenerate", n_inside, n_bound, n_degen);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
